FILE: design/gbts_pkg.sv
// Shared constants and types for the gap buffer text store.
// No dependencies; every other file in the block imports this package.
`timescale 1ns / 1ps

package gbts_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int LEN_W    = $clog2(CAPACITY + 1);
   localparam int UNIT_W   = 16;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_ERASE  = 2'd1,
      KIND_COUNT  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

endpackage

FILE: design/gbts_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on gbts_pkg for field widths.
`timescale 1ns / 1ps

interface gbts_req_if;
   import gbts_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [LEN_W-1:0]  position;
   logic [LEN_W-1:0]  span;
   logic [UNIT_W-1:0] unit_value;

   modport source (output valid, output kind, output position, output span,
                   output unit_value, input ready);
   modport sink   (input valid, input kind, input position, input span,
                   input unit_value, output ready);
endinterface

interface gbts_rsp_if;
   import gbts_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [UNIT_W-1:0]   read_unit;
   logic [LEN_W-1:0]    tally;
   logic [LEN_W-1:0]    text_length;

   modport source (output valid, output status, output read_unit, output tally,
                   output text_length, input ready);
   modport sink   (input valid, input status, input read_unit, input tally,
                   input text_length, output ready);
endinterface

FILE: design/gap_buffer_text_store.sv
// Gap buffer text store: top level, unit memory, gap mover and span scanner.
// Depends on gbts_pkg and the channel interfaces in gbts_if.sv.
`timescale 1ns / 1ps

// A fixed-capacity gap buffer of 16-bit text units held in one single-port-read,
// single-port-write synchronous RAM (CAPACITY entries, registered read).
// Each request item yields exactly one response item. A rejected item goes
// straight to the response. Insert and erase first move the gap by the distance
// |position - gap start|, the mover copying one unit per cycle through the RAM
// read port; count and read use the scanner, which reads one unit per cycle.
// A new item is accepted whenever the engine is idle, even while the previous
// response is still waiting in the output register. Stored units are not
// cleared at reset; only entries that hold text are ever read.
module gap_buffer_text_store (
   input  logic clock,
   input  logic reset,
   gbts_req_if.sink   req,
   gbts_rsp_if.source rsp
);
   import gbts_pkg::*;

   localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

   // unit store
   logic [UNIT_W-1:0] mem [CAPACITY];
   logic              mem_re;
   logic [ADDR_W-1:0] mem_ra;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_wa;
   logic [UNIT_W-1:0] mem_wd;
   logic [UNIT_W-1:0] mem_q;

   // control and state
   state_type         state_ff, state_in;
   kind_type          op_ff, op_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  span_ff, span_in;
   logic [UNIT_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0]  gs_ff, gs_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] src_ff, src_in;
   logic [ADDR_W-1:0] dst_ff, dst_in;
   logic              up_ff, up_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  lidx_ff, lidx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0] wr_addr_ff, wr_addr_in;
   logic [LEN_W-1:0]  tally_ff, tally_in;
   logic [UNIT_W-1:0] rdu_ff, rdu_in;
   status_type        stat_ff, stat_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [UNIT_W-1:0]   rsp_unit_ff, rsp_unit_in;
   logic [LEN_W-1:0]    rsp_tally_ff, rsp_tally_in;
   logic [LEN_W-1:0]    rsp_len_ff, rsp_len_in;

   logic [LEN_W-1:0]  gap;
   logic [LEN_W:0]    req_end;
   logic [ADDR_W-1:0] scan_addr;
   logic              is_move;
   logic              rsp_load;

   assign gap       = CAP_L - len_ff;
   assign req_end   = {1'b0, req.position} + {1'b0, req.span};
   // logical to physical: units past the gap start sit beyond the gap
   assign scan_addr = (lidx_ff < gs_ff) ? lidx_ff[ADDR_W-1:0]
                                        : ADDR_W'(lidx_ff + gap);
   assign is_move   = (op_ff == KIND_INSERT) || (op_ff == KIND_ERASE);
   assign rsp_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.read_unit   = rsp_unit_ff;
   assign rsp.tally       = rsp_tally_ff;
   assign rsp.text_length = rsp_len_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         mem_q <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gs_ff        <= '0;
         len_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gs_ff        <= gs_in;
         len_ff       <= len_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      span_ff       <= span_in;
      val_ff        <= val_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      up_ff         <= up_in;
      cnt_ff        <= cnt_in;
      lidx_ff       <= lidx_in;
      wr_addr_ff    <= wr_addr_in;
      tally_ff      <= tally_in;
      rdu_ff        <= rdu_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_unit_ff   <= rsp_unit_in;
      rsp_tally_ff  <= rsp_tally_in;
      rsp_len_ff    <= rsp_len_in;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      span_in       = span_ff;
      val_in        = val_ff;
      gs_in         = gs_ff;
      len_in        = len_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      up_in         = up_ff;
      cnt_in        = cnt_ff;
      lidx_in       = lidx_ff;
      rd_vld_in     = 1'b0;
      wr_addr_in    = wr_addr_ff;
      tally_in      = tally_ff;
      rdu_in        = rdu_ff;
      stat_in       = stat_ff;
      mem_re        = 1'b0;
      mem_ra        = src_ff;
      mem_we        = 1'b0;
      mem_wa        = wr_addr_ff;
      mem_wd        = mem_q;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_unit_in   = rsp_unit_ff;
      rsp_tally_in  = rsp_tally_ff;
      rsp_len_in    = rsp_len_ff;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in    = kind_type'(req.kind);
               pos_in   = req.position;
               span_in  = req.span;
               val_in   = req.unit_value;
               lidx_in  = req.position;
               tally_in = '0;
               rdu_in   = '0;
               stat_in  = STATUS_OK;
               state_in = S_RUN;
               cnt_in   = '0;
               up_in    = 1'b1;
               src_in   = '0;
               dst_in   = '0;
               case (kind_type'(req.kind))
                  KIND_INSERT, KIND_ERASE: begin
                     if ((kind_type'(req.kind) == KIND_INSERT) && (len_ff == CAP_L)) begin
                        stat_in  = STATUS_FULL;
                        state_in = S_DONE;
                     end else if (((kind_type'(req.kind) == KIND_INSERT) &&
                                   (req.position > len_ff)) ||
                                  ((kind_type'(req.kind) == KIND_ERASE) &&
                                   (req_end > {1'b0, len_ff}))) begin
                        stat_in  = STATUS_RANGE;
                        state_in = S_DONE;
                     end else if (req.position > gs_ff) begin
                        // gap moves right: pull units from beyond the gap, ascending
                        up_in  = 1'b1;
                        src_in = ADDR_W'(gs_ff + gap);
                        dst_in = gs_ff[ADDR_W-1:0];
                        cnt_in = req.position - gs_ff;
                     end else if (req.position < gs_ff) begin
                        // gap moves left: push units past the gap, descending
                        up_in  = 1'b0;
                        src_in = ADDR_W'(gs_ff - 1'b1);
                        dst_in = ADDR_W'(gs_ff - 1'b1 + gap);
                        cnt_in = gs_ff - req.position;
                     end
                  end
                  KIND_COUNT: begin
                     cnt_in = req.span;
                     if (req_end > {1'b0, len_ff}) begin
                        stat_in  = STATUS_RANGE;
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     cnt_in = LEN_W'(1);
                     if (req.position >= len_ff) begin
                        stat_in  = STATUS_RANGE;
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end

         S_RUN: begin
            // returned data from the read issued last cycle
            if (rd_vld_ff) begin
               if (is_move) begin
                  mem_we = 1'b1;
                  mem_wa = wr_addr_ff;
                  mem_wd = mem_q;
               end else if (op_ff == KIND_COUNT) begin
                  if (mem_q == val_ff) begin
                     tally_in = tally_ff + 1'b1;
                  end
               end else begin
                  rdu_in = mem_q;
               end
            end

            if (cnt_ff != '0) begin
               mem_re    = 1'b1;
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff - 1'b1;
               if (is_move) begin
                  mem_ra     = src_ff;
                  wr_addr_in = dst_ff;
                  src_in     = up_ff ? src_ff + 1'b1 : src_ff - 1'b1;
                  dst_in     = up_ff ? dst_ff + 1'b1 : dst_ff - 1'b1;
               end else begin
                  mem_ra  = scan_addr;
                  lidx_in = lidx_ff + 1'b1;
               end
            end else if (!rd_vld_ff) begin
               // pipeline empty: commit the gap and length updates
               state_in = S_DONE;
               if (op_ff == KIND_INSERT) begin
                  mem_we = 1'b1;
                  mem_wa = pos_ff[ADDR_W-1:0];
                  mem_wd = val_ff;
                  gs_in  = pos_ff + 1'b1;
                  len_in = len_ff + 1'b1;
               end else if (op_ff == KIND_ERASE) begin
                  gs_in  = pos_ff;
                  len_in = len_ff - span_ff;
               end
            end
         end

         S_DONE: begin
            if (rsp_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_len_in    = len_ff;
               rsp_unit_in   = ((stat_ff == STATUS_OK) && (op_ff == KIND_READ)) ?
                               rdu_ff : '0;
               rsp_tally_in  = ((stat_ff == STATUS_OK) && (op_ff == KIND_COUNT)) ?
                               tally_ff : '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: verif/tb_gap_buffer_text_store.sv
// Self-checking testbench for the gap buffer text store: directed items, then random
// edits, each result checked against a behavioural text model.
// Depends on gbts_pkg, the channel interfaces in gbts_if.sv and the block itself.
`timescale 1ns / 1ps

module tb_gap_buffer_text_store;
   import gbts_pkg::*;

   // Cycles with no item moving on either channel before the run is abandoned. The slowest
   // single item (a count over the full store, or a gap move across it) and the long receiver
   // hold-off of HOLD_CYCLES both fit well inside this limit, leaving ample headroom.
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_EDITS   = 120;
   localparam int HOLD_CYCLES    = 300;
   // Reply counts at which the receiver stops for a long stretch: one early (HOLD_SECOND), one later (HOLD_FIRST)
   localparam int HOLD_FIRST     = 100;
   localparam int HOLD_SECOND    = 20;
   localparam int MAX_REPORTS    = 100;

   typedef struct packed {
      kind_type          kind;
      logic [LEN_W-1:0]  position;
      logic [LEN_W-1:0]  span;
      logic [UNIT_W-1:0] unit_value;
   } edit_item_type;

   typedef struct packed {
      status_type        status;
      logic [UNIT_W-1:0] read_unit;
      logic [LEN_W-1:0]  tally;
      logic [LEN_W-1:0]  text_length;
   } reply_item_type;

   logic clock;
   logic reset;

   gbts_req_if req_ch ();
   gbts_rsp_if rsp_ch ();

   gap_buffer_text_store dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Behavioural view of the text: logical order only, the gap is invisible from outside
   logic [UNIT_W-1:0] text_units[$];
   edit_item_type     pending_edits[$];
   reply_item_type    expected_replies[$];

   int  plan_len;          // text length the stimulus expects, tracked as items are queued
   int  total_edits;
   int  edits_accepted;
   int  replies_seen;
   int  outstanding;
   int  mismatch_count;
   int  quiet_cycles;
   int  hold_left;
   int  hold_mark;
   logic req_taken;        // the item on req_ch went through at the last rising edge
   logic steady_phase;

   // A long stretch in the middle of the run goes with neither side idling
   assign steady_phase = (edits_accepted >= 30) && (edits_accepted < 70);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Prediction: apply one accepted item to the text and work out its reply
   // ---------------------------------------------------------------------------------------
   function automatic reply_item_type apply_edit(edit_item_type e);
      reply_item_type r;
      int unsigned pos;
      int unsigned span;
      int unsigned len;
      int unsigned i;
      r        = '0;
      r.status = STATUS_OK;
      pos      = e.position;
      span     = e.span;
      len      = text_units.size();
      case (e.kind)
         KIND_INSERT: begin
            // Full is checked ahead of the position
            if (len >= CAPACITY) r.status = STATUS_FULL;
            else if (pos > len) r.status = STATUS_RANGE;
            else text_units.insert(pos, e.unit_value);
         end
         KIND_ERASE: begin
            if (pos + span > len) r.status = STATUS_RANGE;
            else repeat (span) text_units.delete(pos);
         end
         KIND_COUNT: begin
            if (pos + span > len) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = pos; i < pos + span; i++)
                  if (text_units[i] == e.unit_value) r.tally = r.tally + 1'b1;
            end
         end
         default: begin
            if (pos >= len) r.status = STATUS_RANGE;
            else r.read_unit = text_units[pos];
         end
      endcase
      r.text_length = LEN_W'(text_units.size());
      return r;
   endfunction

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   // Keeps plan_len in step so random positions land mostly inside the text
   task automatic queue_edit(kind_type k, int pos, int span, logic [UNIT_W-1:0] v);
      edit_item_type e;
      e.kind       = k;
      e.position   = LEN_W'(pos);
      e.span       = LEN_W'(span);
      e.unit_value = v;
      pending_edits.push_back(e);
      if (k == KIND_INSERT && plan_len < CAPACITY && pos <= plan_len) plan_len++;
      if (k == KIND_ERASE && pos + span <= plan_len) plan_len -= span;
   endtask

   // A small alphabet makes counts find matches; the rest are fully random units
   function automatic logic [UNIT_W-1:0] pick_unit();
      logic [UNIT_W-1:0] alphabet[4];
      alphabet = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
      if ($urandom_range(0, 2) == 0) return UNIT_W'($urandom);
      return alphabet[$urandom_range(0, 3)];
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: presents items from pending_edits, changes at the falling edge
   // ---------------------------------------------------------------------------------------
   always @(negedge clock) begin : drive_edits
      edit_item_type next_edit;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_edits.size() != 0 && (steady_phase || $urandom_range(0, 99) >= 26)) begin
            next_edit = pending_edits.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.kind       <= next_edit.kind;
            req_ch.position   <= next_edit.position;
            req_ch.span       <= next_edit.span;
            req_ch.unit_value <= next_edit.unit_value;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver side: random stalls, plus two long hold-offs so that the block backs up
   always @(negedge clock) begin : drive_ready
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (hold_left == 0 && hold_mark != replies_seen &&
             (replies_seen == HOLD_FIRST || replies_seen == HOLD_SECOND)) begin
            hold_left = HOLD_CYCLES;
            hold_mark = replies_seen;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady_phase || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: predicts on each accepted edit, checks each accepted reply in order
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      edit_item_type  taken;
      reply_item_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            taken.kind       = kind_type'(req_ch.kind);
            taken.position   = req_ch.position;
            taken.span       = req_ch.span;
            taken.unit_value = req_ch.unit_value;
            expected_replies.push_back(apply_edit(taken));
            edits_accepted++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch($sformatf("reply %0d arrived with nothing expected", replies_seen));
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.status !== want.status)
                  report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                            replies_seen, rsp_ch.status, want.status));
               if (rsp_ch.read_unit !== want.read_unit)
                  report_mismatch($sformatf("reply %0d read_unit %h, expected %h",
                                            replies_seen, rsp_ch.read_unit, want.read_unit));
               if (rsp_ch.tally !== want.tally)
                  report_mismatch($sformatf("reply %0d tally %0d, expected %0d",
                                            replies_seen, rsp_ch.tally, want.tally));
               if (rsp_ch.text_length !== want.text_length)
                  report_mismatch($sformatf("reply %0d text_length %0d, expected %0d",
                                            replies_seen, rsp_ch.text_length, want.text_length));
            end
            replies_seen++;
         end
         outstanding = expected_replies.size();
      end
   end

   // Watchdog: nothing moving on either channel for too long ends the run
   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------------------------
   initial begin : run
      int n;
      int roll;
      int pos;
      int room;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.kind       = '0;
      req_ch.position   = '0;
      req_ch.span       = '0;
      req_ch.unit_value = '0;
      rsp_ch.ready      = 1'b0;
      plan_len          = 0;
      edits_accepted    = 0;
      replies_seen      = 0;
      outstanding       = 0;
      mismatch_count    = 0;
      quiet_cycles      = 0;
      hold_left         = 0;
      hold_mark         = -1;

      // Directed: empty text first
      queue_edit(KIND_READ, 0, 0, '0);                 // read of empty text
      queue_edit(KIND_COUNT, 0, 0, 16'hFFFF);          // zero span is fine
      queue_edit(KIND_ERASE, 0, 0, '0);                // zero-span erase on empty text
      queue_edit(KIND_INSERT, 1, 0, 16'h1234);         // insert past the end
      queue_edit(KIND_INSERT, 0, 0, 16'hFFFF);         // append to empty text
      queue_edit(KIND_INSERT, 1, 0, 16'h0000);         // append
      queue_edit(KIND_INSERT, 0, 0, 16'h8000);         // insert at the front, gap moves back
      queue_edit(KIND_INSERT, 1, 0, 16'h0001);         // insert in the middle
      for (n = 0; n < 4; n++) queue_edit(KIND_READ, n, 0, '0);
      queue_edit(KIND_READ, 4, 0, '0);                 // read at the length
      queue_edit(KIND_COUNT, 0, 4, 16'hFFFF);
      queue_edit(KIND_COUNT, 2, 3, 16'h0000);          // span past the end
      queue_edit(KIND_COUNT, 4, 0, 16'h0000);          // empty span at the end
      queue_edit(KIND_ERASE, 1, 2, '0);                // drop the middle
      queue_edit(KIND_READ, 1, 0, '0);
      queue_edit(KIND_ERASE, 8191, 8191, '0);          // all-ones position and span
      queue_edit(KIND_INSERT, 8191, 0, 16'hFFFF);
      queue_edit(KIND_READ, 8191, 0, '0);

      // Random edits: mostly well-formed, with some noise across the full field ranges
      for (n = 0; n < RANDOM_EDITS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            queue_edit(kind_type'($urandom_range(0, 3)), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), UNIT_W'($urandom));
         end else if (roll < 42 || plan_len == 0) begin
            queue_edit(KIND_INSERT, $urandom_range(0, plan_len), 0, pick_unit());
         end else if (roll < 54) begin
            pos  = $urandom_range(0, plan_len);
            room = plan_len - pos;
            queue_edit(KIND_ERASE, pos, $urandom_range(0, (room < 12) ? room : 12), '0);
         end else if (roll < 74) begin
            pos = $urandom_range(0, plan_len);
            queue_edit(KIND_COUNT, pos, $urandom_range(0, plan_len - pos), pick_unit());
         end else begin
            queue_edit(KIND_READ, $urandom_range(0, plan_len - 1), 0, '0);
         end
      end
      total_edits = pending_edits.size();

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      wait (edits_accepted == total_edits && outstanding == 0);
      // Every item gives one reply, so only a short quiet spell is needed to catch strays
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
